@@ hdl/pps_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the preemptive priority scheduler.
// Used by the scheduler cells, the top level and the port checker; no dependencies.
package pps_pkg;

   localparam int MAX_PROCESSES = 16;
   localparam int IDX_W         = $clog2(MAX_PROCESSES);
   localparam int CNT_W         = $clog2(MAX_PROCESSES + 1);

   localparam int ARR_W   = 12;
   localparam int BURST_W = 8;
   localparam int PRI_W   = 8;
   localparam int TIME_W  = 13;
   localparam int JOB_W   = 5;

   // Fields of one job as it is loaded.
   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [PRI_W-1:0]   prio;
   } job_data_type;

   // What a cell hands to its lower neighbor while results are shifted out.
   typedef struct packed {
      logic [ARR_W-1:0]   arrival;
      logic [BURST_W-1:0] burst;
      logic [TIME_W-1:0]  completion;
   } cell_data_type;

   // Best candidate so far, rippling from cell 0 toward the tail.
   typedef struct packed {
      logic             found;
      logic [PRI_W-1:0] prio;
      logic [IDX_W-1:0] idx;
      logic             last_unit;
   } sched_token_type;

   // Broadcast control from the sequencer to every cell.
   typedef struct packed {
      logic              load;
      logic              shift;
      logic              dec;
      logic [IDX_W-1:0]  dec_idx;
      logic [CNT_W-1:0]  job_count;
      logic [TIME_W-1:0] tick;
      logic [TIME_W-1:0] next_tick;
   } cell_ctrl_type;

endpackage

@@ hdl/pps_cell.sv @@
`timescale 1ns / 1ps
// One scheduler cell: holds a single job and takes part in the priority ripple.
// Depends on pps_pkg.
module pps_cell (
   input  logic                     clock,
   input  logic [pps_pkg::IDX_W-1:0] cell_index,
   input  pps_pkg::cell_ctrl_type   ctrl,
   input  pps_pkg::job_data_type    load_data,
   input  pps_pkg::cell_data_type   nbr_data,
   input  pps_pkg::sched_token_type token_in,
   output pps_pkg::cell_data_type   own_data,
   output pps_pkg::sched_token_type token_out
);
   import pps_pkg::*;

   logic [ARR_W-1:0]   arrival_ff;
   logic [BURST_W-1:0] burst_ff;
   logic [PRI_W-1:0]   priority_ff;
   logic [BURST_W-1:0] remaining_ff;
   logic [TIME_W-1:0]  completion_ff;
   sched_token_type    token_ff;
   sched_token_type    token_in_next;

   logic active;
   logic eligible;
   logic take;

   assign active   = CNT_W'(cell_index) < ctrl.job_count;
   assign eligible = active && (TIME_W'(arrival_ff) <= ctrl.tick) && (remaining_ff != '0);
   // Strict compare: on equal priority the earlier cell keeps the token.
   assign take     = eligible && (!token_in.found || (priority_ff < token_in.prio));

   always_comb begin
      token_in_next = token_in;
      if (take) begin
         token_in_next.found     = 1'b1;
         token_in_next.prio      = priority_ff;
         token_in_next.idx       = cell_index;
         token_in_next.last_unit = (remaining_ff == BURST_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      token_ff <= token_in_next;
      if (ctrl.load && (ctrl.job_count == CNT_W'(cell_index))) begin
         arrival_ff   <= load_data.arrival;
         burst_ff     <= load_data.burst;
         priority_ff  <= load_data.prio;
         remaining_ff <= load_data.burst;
      end else if (ctrl.shift) begin
         arrival_ff    <= nbr_data.arrival;
         burst_ff      <= nbr_data.burst;
         completion_ff <= nbr_data.completion;
      end else if (ctrl.dec && (ctrl.dec_idx == cell_index)) begin
         remaining_ff <= remaining_ff - BURST_W'(1);
         if (remaining_ff == BURST_W'(1)) begin
            completion_ff <= ctrl.next_tick;
         end
      end
   end

   assign own_data.arrival    = arrival_ff;
   assign own_data.burst      = burst_ff;
   assign own_data.completion = completion_ff;
   assign token_out           = token_ff;

endmodule

@@ hdl/preemptive_priority_scheduler.sv @@
`timescale 1ns / 1ps
// Preemptive priority scheduler top level: sequencer plus a row of scheduler cells.
// Depends on pps_pkg and pps_cell.
//
// Jobs are loaded one item per cycle while busy is low; the item with last_item set ends
// loading and raises busy. Then, in each simulated tick, the best-candidate token ripples
// through the row of cells, one cell per cycle, and after the ripple the chosen job is
// updated; the number of ticks is the completion time of the last
// job to finish. After that one result per job is strobed on rsp_valid, in load order,
// in consecutive cycles. The receiver cannot stall: every result is valid for exactly
// one cycle. busy falls with the last result, and the next item starts a new batch.
// Jobs beyond MAX_PROCESSES in one batch are dropped.
module preemptive_priority_scheduler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [pps_pkg::ARR_W-1:0]     req_arrival_time,
   input  logic [pps_pkg::BURST_W-1:0]   req_burst_time,
   input  logic [pps_pkg::PRI_W-1:0]     req_job_priority,
   input  logic                          req_last_item,
   output logic                          rsp_valid,
   output logic [pps_pkg::JOB_W-1:0]     rsp_job_number,
   output logic [pps_pkg::TIME_W-1:0]    rsp_completion_time,
   output logic [pps_pkg::TIME_W-1:0]    rsp_turnaround_time,
   output logic [pps_pkg::TIME_W-1:0]    rsp_waiting_time,
   output logic                          rsp_last_result
);
   import pps_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_OUTPUT
   } state_type;

   state_type          state_ff;
   logic [CNT_W-1:0]   job_count_ff;
   logic [CNT_W-1:0]   done_ff;
   logic [CNT_W-1:0]   sweep_ff;
   logic [CNT_W-1:0]   out_cnt_ff;
   logic [TIME_W-1:0]  tick_ff;

   logic               rsp_valid_ff;
   logic [JOB_W-1:0]   rsp_job_number_ff;
   logic [TIME_W-1:0]  rsp_completion_ff;
   logic [TIME_W-1:0]  rsp_turnaround_ff;
   logic [TIME_W-1:0]  rsp_waiting_ff;
   logic               rsp_last_ff;

   logic [TIME_W-1:0]  tick_in;
   logic [CNT_W-1:0]   done_in;
   logic [CNT_W-1:0]   out_num;
   logic               accept;
   logic               sweep_end;
   logic [TIME_W-1:0]  turnaround;
   logic [TIME_W-1:0]  waiting;

   cell_ctrl_type      ctrl;
   job_data_type       load_data;
   cell_data_type      cell_data  [MAX_PROCESSES];
   sched_token_type    cell_token [MAX_PROCESSES];
   sched_token_type    tail;

   assign accept    = start && (state_ff == ST_IDLE);
   assign tail      = cell_token[MAX_PROCESSES-1];
   assign sweep_end = (state_ff == ST_SEARCH) && (sweep_ff == CNT_W'(MAX_PROCESSES));
   assign tick_in   = tick_ff + TIME_W'(1);
   assign done_in   = done_ff + CNT_W'(sweep_end && tail.found && tail.last_unit);
   assign out_num   = out_cnt_ff + CNT_W'(1);

   // A zero burst would never complete, so it is stored as one.
   assign load_data.arrival  = req_arrival_time;
   assign load_data.burst    = (req_burst_time == '0) ? BURST_W'(1) : req_burst_time;
   assign load_data.prio     = req_job_priority;

   assign ctrl.load      = accept && (job_count_ff < CNT_W'(MAX_PROCESSES));
   assign ctrl.shift     = (state_ff == ST_OUTPUT);
   assign ctrl.dec       = sweep_end && tail.found;
   assign ctrl.dec_idx   = tail.idx;
   assign ctrl.job_count = job_count_ff;
   assign ctrl.tick      = tick_ff;
   assign ctrl.next_tick = tick_in;

   for (genvar g = 0; g < MAX_PROCESSES; g++) begin : g_cell
      sched_token_type prev_token;
      cell_data_type   next_data;
      if (g == 0) begin : g_head
         assign prev_token = '0;
      end else begin : g_body
         assign prev_token = cell_token[g-1];
      end
      if (g == MAX_PROCESSES - 1) begin : g_tail
         assign next_data = '0;
      end else begin : g_inner
         assign next_data = cell_data[g+1];
      end
      pps_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(g)),
         .ctrl       (ctrl),
         .load_data  (load_data),
         .nbr_data   (next_data),
         .token_in   (prev_token),
         .own_data   (cell_data[g]),
         .token_out  (cell_token[g])
      );
   end

   // Results leave from cell 0 while the row shifts down by one each cycle.
   assign turnaround = cell_data[0].completion - TIME_W'(cell_data[0].arrival);
   assign waiting    = turnaround - TIME_W'(cell_data[0].burst);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         job_count_ff <= '0;
         done_ff      <= '0;
         sweep_ff     <= '0;
         out_cnt_ff   <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (ctrl.load) begin
                     job_count_ff <= job_count_ff + CNT_W'(1);
                  end
                  if (req_last_item) begin
                     state_ff <= ST_SEARCH;
                     tick_ff  <= '0;
                     done_ff  <= '0;
                     sweep_ff <= '0;
                  end
               end
            end
            ST_SEARCH: begin
               if (sweep_end) begin
                  tick_ff  <= tick_in;
                  done_ff  <= done_in;
                  sweep_ff <= '0;
                  if (done_in == job_count_ff) begin
                     state_ff   <= ST_OUTPUT;
                     out_cnt_ff <= '0;
                  end
               end else begin
                  sweep_ff <= sweep_ff + CNT_W'(1);
               end
            end
            ST_OUTPUT: begin
               rsp_valid_ff      <= 1'b1;
               rsp_job_number_ff <= JOB_W'(out_num);
               rsp_completion_ff <= cell_data[0].completion;
               rsp_turnaround_ff <= turnaround;
               rsp_waiting_ff    <= waiting;
               rsp_last_ff       <= (out_num == job_count_ff);
               out_cnt_ff        <= out_num;
               if (out_num == job_count_ff) begin
                  state_ff     <= ST_IDLE;
                  job_count_ff <= '0;
                  tick_ff      <= '0;
                  done_ff      <= '0;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_job_number      = rsp_job_number_ff;
   assign rsp_completion_time = rsp_completion_ff;
   assign rsp_turnaround_time = rsp_turnaround_ff;
   assign rsp_waiting_time    = rsp_waiting_ff;
   assign rsp_last_result     = rsp_last_ff;

endmodule

@@ hdl/pps_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the preemptive priority scheduler, bound to the top level.
// Depends on pps_pkg and preemptive_priority_scheduler.
module pps_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          req_last_item,
   input logic                          rsp_valid,
   input logic [pps_pkg::TIME_W-1:0]    rsp_turnaround_time,
   input logic [pps_pkg::TIME_W-1:0]    rsp_waiting_time,
   input logic                          rsp_last_result
);
   import pps_pkg::*;

   // The final item of a batch must start the schedule.
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_item |=> busy)
      else $error("last item did not raise busy");

   // Results other than the final one are only produced while the batch is running.
   a_busy_during_results: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_result |-> busy)
      else $error("result strobed outside a running batch");

   // Every job has at least one unit of work, so waiting never equals turnaround.
   a_burst_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_turnaround_time != rsp_waiting_time)
      else $error("waiting time equals turnaround time");

   // Nothing follows the final result of a batch.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |=> !rsp_valid)
      else $error("result strobed after the final one");

endmodule

bind preemptive_priority_scheduler pps_checker u_pps_checker (.*);
